// ===== hdl/swrf_pkg.sv =====
package swrf_pkg;

    localparam int SYMBOLS      = 16;
    localparam int WINDOW_DEPTH = 64;
    localparam int SYM_W        = $clog2(SYMBOLS);
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = PTR_W + 1;
    localparam int ADDR_W       = SYM_W + PTR_W;
    localparam int MEM_DEPTH    = SYMBOLS * WINDOW_DEPTH;
    localparam int SAMPLE_W     = 48 + 32 + 16 + 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [23:0] BPS_SCALE = 24'd2560000;
    localparam logic [23:0] RANGE_MAX = 24'hFFFFFF;

    localparam logic [2:0] CFG_WINDOW   = 3'd0;
    localparam logic [2:0] CFG_MIN_SAMP = 3'd1;
    localparam logic [2:0] CFG_MAX_SPRD = 3'd2;
    localparam logic [2:0] CFG_MIN_IMB  = 3'd3;
    localparam logic [2:0] CFG_MIN_FLOW = 3'd4;

    localparam logic [2:0] RSN_OK       = 3'd0;
    localparam logic [2:0] RSN_UNINIT   = 3'd1;
    localparam logic [2:0] RSN_EMPTY    = 3'd2;
    localparam logic [2:0] RSN_FEW      = 3'd3;
    localparam logic [2:0] RSN_SPREAD   = 3'd4;
    localparam logic [2:0] RSN_BOTHWEAK = 3'd5;
    localparam logic [2:0] RSN_IMB      = 3'd6;
    localparam logic [2:0] RSN_FLOW     = 3'd7;

    // word queued from front to back
    typedef struct packed {
        logic              is_query;
        logic              uninit;
        logic [SYM_W-1:0]  sym;
        logic [47:0]       time_ms;
        logic [31:0]       mid;
        logic [15:0]       spread;
        logic [15:0]       imb;
        logic [31:0]       flow;
    } t_cmd;

    typedef struct packed {
        logic [6:0]  sample_count;
        logic [15:0] avg_spread;
        logic [23:0] range_bps;
        logic [31:0] activity_bps;
        logic [15:0] imbalance_range;
        logic        recent_flow;
        logic        tradable;
        logic [2:0]  reason;
    } t_result;

endpackage

// ===== hdl/swrf_ram.sv =====
module swrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/swrf_divider.sv =====
// restoring divider, 64 by 32 bits, one quotient bit a cycle
module swrf_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_quot;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_try;
    logic [33:0] w_diff;

    assign w_try  = {r_rem[31:0], r_quot[63]};
    assign w_diff = {1'b0, w_try} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_diff[33]) begin
                r_rem  <= w_diff[32:0];
                r_quot <= {r_quot[62:0], 1'b1};
            end else begin
                r_rem  <= w_try;
                r_quot <= {r_quot[62:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== hdl/swrf_front.sv =====
// takes input words, checks the symbol and pushes commands to the queue
module swrf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_op,
    input  logic [3:0]             i_symbol_id,
    input  logic [47:0]            i_time_ms,
    input  logic [31:0]            i_mid_price,
    input  logic [15:0]            i_spread_bps,
    input  logic [15:0]            i_imbalance,
    input  logic [31:0]            i_flow_qty,
    output logic                   o_q_valid,
    input  logic                   i_q_pop,
    output swrf_pkg::t_cmd         o_q_cmd
);
    swrf_pkg::t_cmd r_q [swrf_pkg::QUEUE_DEPTH];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       w_push;
    logic       w_in_range;
    swrf_pkg::t_cmd w_cmd;

    assign w_in_range = ({28'd0, i_symbol_id} < 32'(swrf_pkg::SYMBOLS));
    assign o_ready    = (r_cnt != 2'(swrf_pkg::QUEUE_DEPTH));
    assign w_push     = i_valid && o_ready && (i_op || w_in_range);

    always_comb begin
        w_cmd          = '0;
        w_cmd.is_query = i_op;
        w_cmd.uninit   = !w_in_range;
        w_cmd.sym      = i_symbol_id[swrf_pkg::SYM_W-1:0];
        w_cmd.time_ms  = i_time_ms;
        w_cmd.mid      = i_mid_price;
        w_cmd.spread   = i_spread_bps;
        w_cmd.imb      = i_imbalance;
        w_cmd.flow     = i_flow_qty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (i_q_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_cmd;
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rd];
endmodule

// ===== hdl/swrf_back.sv =====
// executes stores and queries against the sample memory
module swrf_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  swrf_pkg::t_cmd         i_q_cmd,
    input  logic [31:0]            i_window_ms,
    input  logic [6:0]             i_min_samples,
    input  logic [15:0]            i_max_avg_spread,
    input  logic [15:0]            i_min_imbalance_range,
    input  logic [31:0]            i_min_flow_qty,
    output logic                   o_valid,
    input  logic                   i_ready,
    output swrf_pkg::t_result      o_res
);
    localparam int PW = swrf_pkg::PTR_W;
    localparam int CW = swrf_pkg::CNT_W;
    localparam int AW = swrf_pkg::ADDR_W;
    localparam logic [63:0] BPS_SCALE_64 = {40'd0, swrf_pkg::BPS_SCALE};

    typedef enum logic [3:0] {
        S_IDLE, S_PRUNE_RD, S_PRUNE_WAIT, S_PRUNE_CHK, S_WALK_RD, S_WALK_WAIT,
        S_WALK_ACC, S_ACT_DIV, S_RANGE_DIV, S_MEAN_DIV, S_FINISH, S_OUT
    } t_state;

    t_state r_state;
    logic [PW-1:0] r_head [swrf_pkg::SYMBOLS];
    logic [CW-1:0] r_count [swrf_pkg::SYMBOLS];
    logic          r_seen [swrf_pkg::SYMBOLS];

    swrf_pkg::t_cmd    r_cmd;
    swrf_pkg::t_result r_res;
    swrf_pkg::t_result r_out;
    logic              r_valid;
    logic [PW-1:0]     r_hd;
    logic [CW-1:0]     r_n;
    logic [CW-1:0]     r_k;
    logic [21:0]       r_ssum;
    logic [31:0]       r_min_mid, r_max_mid, r_prev, r_cur;
    logic signed [15:0] r_min_imb, r_max_imb;
    logic [32:0]       r_act;
    logic              r_sym_done;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [swrf_pkg::SAMPLE_W-1:0] w_wdata, w_rdata;
    logic [47:0]   w_rtime;
    logic [31:0]   w_rmid;
    logic [15:0]   w_rspread;
    logic signed [15:0] w_rimb;

    logic          r_div_start;
    logic [63:0]   r_div_num;
    logic [31:0]   r_div_den;
    logic          w_div_busy, w_div_done;
    logic [63:0]   w_div_quot;
    logic          w_div_go;

    logic [PW-1:0] w_sh;
    logic [CW-1:0] w_sc;
    logic [PW-1:0] w_rptr;
    logic [31:0]   w_diff;
    logic [16:0]   w_imb_rng;
    logic          w_flow_ok, w_enough, w_spread_ok, w_imb_alive, w_trad;
    logic [38:0]   w_lim;

    assign w_sh  = r_head[i_q_cmd.sym];
    assign w_sc  = r_count[i_q_cmd.sym];
    assign w_rptr = r_hd + r_k[PW-1:0];
    assign w_raddr = {r_cmd.sym, w_rptr};

    assign w_we    = (r_state == S_IDLE) && i_q_valid && !i_q_cmd.is_query;
    assign w_waddr = {i_q_cmd.sym, (w_sc[CW-1] ? w_sh : w_sh + w_sc[PW-1:0])};
    assign w_wdata = {i_q_cmd.time_ms, i_q_cmd.mid, i_q_cmd.spread, i_q_cmd.imb};
    assign {w_rtime, w_rmid, w_rspread, w_rimb} = w_rdata;

    swrf_ram #(.WIDTH(swrf_pkg::SAMPLE_W), .DEPTH(swrf_pkg::MEM_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    swrf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // divider kicks: one per activity step, then range (skipped when the minimum mid is zero) and mean back to back
    assign w_div_go = ((r_state == S_WALK_ACC) && r_k != '0 && r_prev != '0)
                   || ((r_state == S_RANGE_DIV) && !w_div_busy && !r_div_start);

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_diff  = (w_rmid >= r_prev) ? w_rmid - r_prev : r_prev - w_rmid;
    assign w_imb_rng = 17'($signed({r_max_imb[15], r_max_imb})
                     - $signed({r_min_imb[15], r_min_imb}));
    assign w_flow_ok = r_cmd.flow >= i_min_flow_qty;
    assign w_enough  = {1'b0, r_n} >= {1'b0, i_min_samples};
    assign w_lim     = 39'(i_max_avg_spread) * 39'(r_n);
    assign w_spread_ok = 39'(r_ssum) <= w_lim;
    assign w_imb_alive = w_imb_rng[15:0] >= i_min_imbalance_range;
    assign w_trad    = w_enough && w_spread_ok && (w_imb_alive || w_flow_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_div_start <= 1'b0;
            for (int s = 0; s < swrf_pkg::SYMBOLS; s++) begin
                r_head[s]  <= '0;
                r_count[s] <= '0;
                r_seen[s]  <= 1'b0;
            end
        end else begin
            r_div_start <= w_div_go;
            if (r_state == S_OUT) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_q_cmd;
                        if (!i_q_cmd.is_query) begin
                            r_seen[i_q_cmd.sym] <= 1'b1;
                            if (w_sc[CW-1]) r_head[i_q_cmd.sym] <= w_sh + 1'b1;
                            else r_count[i_q_cmd.sym] <= w_sc + 1'b1;
                        end else if (i_q_cmd.uninit || !r_seen[i_q_cmd.sym]) begin
                            r_res <= '{reason: swrf_pkg::RSN_UNINIT, default: '0};
                            r_state <= S_OUT;
                        end else begin
                            r_res <= '0;
                            r_hd <= w_sh;
                            r_n  <= w_sc;
                            r_k  <= '0;
                            r_state <= S_PRUNE_RD;
                        end
                    end
                end
                S_PRUNE_RD: begin
                    if (r_n == '0) begin
                        r_head[r_cmd.sym]  <= r_hd;
                        r_count[r_cmd.sym] <= '0;
                        r_res.reason <= swrf_pkg::RSN_EMPTY;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PRUNE_WAIT;
                    end
                end
                S_PRUNE_WAIT: r_state <= S_PRUNE_CHK;
                S_PRUNE_CHK: begin
                    if (r_cmd.time_ms > w_rtime
                        && (r_cmd.time_ms - w_rtime) > {16'd0, i_window_ms}) begin
                        r_hd <= r_hd + 1'b1;
                        r_n  <= r_n - 1'b1;
                        r_state <= S_PRUNE_RD;
                    end else begin
                        r_head[r_cmd.sym]  <= r_hd;
                        r_count[r_cmd.sym] <= r_n;
                        r_ssum <= '0;
                        r_act  <= '0;
                        r_min_mid <= w_rmid;
                        r_max_mid <= w_rmid;
                        r_prev    <= w_rmid;
                        r_min_imb <= w_rimb;
                        r_max_imb <= w_rimb;
                        r_state <= S_WALK_RD;
                    end
                end
                S_WALK_RD: r_state <= S_WALK_WAIT;
                S_WALK_WAIT: r_state <= S_WALK_ACC;
                S_WALK_ACC: begin
                    r_ssum <= r_ssum + 22'(w_rspread);
                    if (w_rmid < r_min_mid) r_min_mid <= w_rmid;
                    if (w_rmid > r_max_mid) r_max_mid <= w_rmid;
                    if (w_rimb < r_min_imb) r_min_imb <= w_rimb;
                    if (w_rimb > r_max_imb) r_max_imb <= w_rimb;
                    r_cur <= w_rmid;
                    r_sym_done <= (r_k == r_n - 1'b1);
                    if (r_k != '0 && r_prev != '0) begin
                        r_state <= S_ACT_DIV;
                        r_div_num <= {32'd0, w_diff} * BPS_SCALE_64;
                        r_div_den <= r_prev;
                    end else begin
                        r_prev <= w_rmid;
                        r_k <= r_k + 1'b1;
                        r_state <= (r_k == r_n - 1'b1) ? S_RANGE_DIV : S_WALK_RD;
                    end
                end
                S_ACT_DIV: begin
                    if (w_div_done) begin
                        if (r_act + 33'(w_div_quot) > 33'h0FFFFFFFF
                            || w_div_quot[63:32] != '0)
                            r_act <= 33'h0FFFFFFFF;
                        else
                            r_act <= r_act + 33'(w_div_quot);
                        r_prev <= r_cur;
                        r_k <= r_k + 1'b1;
                        r_state <= r_sym_done ? S_RANGE_DIV : S_WALK_RD;
                    end
                end
                S_RANGE_DIV: begin
                    if (!w_div_busy && !r_div_start && !w_div_done) begin
                        if (r_min_mid == '0) begin
                            r_res.range_bps <= '0;
                            r_div_num <= 64'(r_ssum);
                            r_div_den <= 32'(r_n);
                            r_state <= S_MEAN_DIV;
                        end else begin
                            r_div_num <= 64'(r_max_mid - r_min_mid) * BPS_SCALE_64;
                            r_div_den <= r_min_mid;
                        end
                    end else if (w_div_done) begin
                        r_res.range_bps <= (w_div_quot[63:24] != '0)
                                         ? swrf_pkg::RANGE_MAX : w_div_quot[23:0];
                        r_div_num <= 64'(r_ssum);
                        r_div_den <= 32'(r_n);
                        r_state <= S_MEAN_DIV;
                    end
                end
                S_MEAN_DIV: begin
                    if (w_div_done) begin
                        r_res.avg_spread <= w_div_quot[15:0];
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_res.sample_count    <= 7'(r_n);
                    r_res.activity_bps    <= r_act[31:0];
                    r_res.imbalance_range <= w_imb_rng[15:0];
                    r_res.recent_flow     <= w_flow_ok;
                    r_res.tradable        <= w_trad;
                    if (w_trad) r_res.reason <= swrf_pkg::RSN_OK;
                    else if (!w_enough) r_res.reason <= swrf_pkg::RSN_FEW;
                    else if (!w_spread_ok) r_res.reason <= swrf_pkg::RSN_SPREAD;
                    else if (!w_imb_alive && !w_flow_ok) r_res.reason <= swrf_pkg::RSN_BOTHWEAK;
                    else if (!w_imb_alive) r_res.reason <= swrf_pkg::RSN_IMB;
                    else r_res.reason <= swrf_pkg::RSN_FLOW;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_valid || i_ready) begin
                        r_out <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;
endmodule

// ===== hdl/sliding_window_regime_filter_top.sv =====
// channel  | direction | handshake          | payload
// input    | in        | i_valid / o_ready  | op, symbol, time, mid, spread, imbalance, flow
// result   | out       | o_valid / i_ready  | count, spread, range, activity, imbalance, flags
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// a store is written from the idle state without leaving it; a query reads each pruned sample
// and each kept sample from memory, with a division in the shared divider per activity step,
// plus divisions for range (skipped when the minimum mid is zero) and mean
// synchronous active-low reset clears ring pointers, counts and seen flags
// a two-word queue decouples input acceptance from execution; the result
// register holds a word until taken while the back end works on the next one
module sliding_window_regime_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [3:0]  i_symbol_id,
    input  logic [47:0] i_time_ms,
    input  logic [31:0] i_mid_price,
    input  logic [15:0] i_spread_bps,
    input  logic [15:0] i_imbalance,
    input  logic [31:0] i_flow_qty,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_sample_count,
    output logic [15:0] o_avg_spread,
    output logic [23:0] o_range_bps,
    output logic [31:0] o_activity_bps,
    output logic [15:0] o_imbalance_range,
    output logic        o_recent_flow,
    output logic        o_tradable,
    output logic [2:0]  o_reason,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_window_ms;
    logic [6:0]  r_min_samples;
    logic [15:0] r_max_avg_spread;
    logic [15:0] r_min_imbalance_range;
    logic [31:0] r_min_flow_qty;

    logic               w_q_valid, w_q_pop;
    swrf_pkg::t_cmd     w_q_cmd;
    swrf_pkg::t_result  w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms           <= 32'd1000;
            r_min_samples         <= 7'd3;
            r_max_avg_spread      <= 16'd384;
            r_min_imbalance_range <= 16'd2048;
            r_min_flow_qty        <= 32'd50;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                swrf_pkg::CFG_WINDOW:   r_window_ms <= i_cfg_data;
                swrf_pkg::CFG_MIN_SAMP: r_min_samples <= i_cfg_data[6:0];
                swrf_pkg::CFG_MAX_SPRD: r_max_avg_spread <= i_cfg_data[15:0];
                swrf_pkg::CFG_MIN_IMB:  r_min_imbalance_range <= i_cfg_data[15:0];
                swrf_pkg::CFG_MIN_FLOW: r_min_flow_qty <= i_cfg_data;
                default: ;
            endcase
        end
    end

    swrf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_symbol_id  (i_symbol_id),
        .i_time_ms    (i_time_ms),
        .i_mid_price  (i_mid_price),
        .i_spread_bps (i_spread_bps),
        .i_imbalance  (i_imbalance),
        .i_flow_qty   (i_flow_qty),
        .o_q_valid    (w_q_valid),
        .i_q_pop      (w_q_pop),
        .o_q_cmd      (w_q_cmd)
    );

    swrf_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_q_valid             (w_q_valid),
        .o_q_pop               (w_q_pop),
        .i_q_cmd               (w_q_cmd),
        .i_window_ms           (r_window_ms),
        .i_min_samples         (r_min_samples),
        .i_max_avg_spread      (r_max_avg_spread),
        .i_min_imbalance_range (r_min_imbalance_range),
        .i_min_flow_qty        (r_min_flow_qty),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_res                 (w_res)
    );

    assign o_sample_count    = w_res.sample_count;
    assign o_avg_spread      = w_res.avg_spread;
    assign o_range_bps       = w_res.range_bps;
    assign o_activity_bps    = w_res.activity_bps;
    assign o_imbalance_range = w_res.imbalance_range;
    assign o_recent_flow     = w_res.recent_flow;
    assign o_tradable        = w_res.tradable;
    assign o_reason          = w_res.reason;
endmodule
